// ===== design/ltrap_pkg.sv =====
`default_nettype none
package ltrap_pkg;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_AREA,
    S_WAIT_AREA,
    S_ADD,
    S_DIV_DECAY,
    S_WAIT_DECAY,
    S_EXP_INIT,
    S_EXP,
    S_MUL_INIT,
    S_MUL,
    S_ROUND,
    S_FINISH
  } ltrap_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic dec_clear;
    logic dec_first;
    logic dec_hold;
    logic load_prod;
    logic div_start;
    logic div_decay;
    logic add;
    logic exp_init;
    logic exp_step;
    logic mul_init;
    logic mul_step;
    logic mul_round;
    logic out_load;
  } ltrap_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear;
    logic started;
    logic same_ts;
    logic tau_zero;
    logic div_busy;
    logic exp_done;
    logic mul_done;
  } ltrap_stat_t;

  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  localparam int TIME_W  = 32;
  localparam int DELTA_W = 16;
  localparam int TAU_W   = 16;
  localparam logic [DELTA_W-1:0] DELTA_MAX = 16'hFFFF;

  // Exponential: remainder below 16.0 in Q4.16, y starts at 1.0 in Q1.30
  localparam int EXP_R_W = 20;
  localparam int EXP_Y_W = 31;
  localparam int EXP_K_W = 5;
  localparam logic [EXP_K_W-1:0] EXP_K_FIRST = 5'd1;
  localparam logic [EXP_K_W-1:0] EXP_K_END   = 5'd17;
  localparam logic [EXP_Y_W-1:0] EXP_Y_ONE   = 31'h4000_0000;
  localparam logic [EXP_Y_W-1:0] EXP_ROUND   = 31'h0000_2000;
  localparam int FACT_W = 17;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_TIME_CONSTANT = 1'b0;

  // round(-ln(1 - 2^-k) * 2^16)
  function automatic logic [15:0] decay_step(input logic [EXP_K_W-1:0] k);
    logic [15:0] c;
    case (k)
      5'd1:    c = 16'd45426;
      5'd2:    c = 16'd18854;
      5'd3:    c = 16'd8751;
      5'd4:    c = 16'd4230;
      5'd5:    c = 16'd2081;
      5'd6:    c = 16'd1032;
      5'd7:    c = 16'd514;
      5'd8:    c = 16'd257;
      5'd9:    c = 16'd128;
      5'd10:   c = 16'd64;
      5'd11:   c = 16'd32;
      5'd12:   c = 16'd16;
      5'd13:   c = 16'd8;
      5'd14:   c = 16'd4;
      5'd15:   c = 16'd2;
      5'd16:   c = 16'd1;
      default: c = 16'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/ltrap_if.sv =====
`default_nettype none
interface ltrap_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic signed [SAMPLE_WIDTH-1:0] sample_value;
  logic [31:0]                    timestamp_ms;

  modport source (output valid, command, sample_value, timestamp_ms, input ready);
  modport sink   (input valid, command, sample_value, timestamp_ms, output ready);
endinterface

interface ltrap_out_if #(
  parameter int ACC_WIDTH = 48
);
  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] integral_value;
  logic                        saturated;

  modport source (output valid, integral_value, saturated, input ready);
  modport sink   (input valid, integral_value, saturated, output ready);
endinterface
`default_nettype wire

// ===== design/ltrap_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ltrap_div #(
  parameter int DW  = 42,
  parameter int DVW = 21
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DW-1:0]  dividend_i,
  input  wire logic [DVW-1:0] divisor_i,
  output logic                busy_o,
  output logic [DW-1:0]       quotient_o
);
  localparam int CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DVW-1:0] rem_q, rem_d;
  logic [DVW-1:0] dvs_q, dvs_d;
  logic [DW-1:0]  quo_q, quo_d;
  logic [DVW:0]   shifted;
  logic [DVW:0]   diff;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (!diff[DVW]) begin
        rem_d = diff[DVW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DVW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// ===== design/ltrap_dp.sv =====
`default_nettype none
module ltrap_dp #(
  parameter int SW  = 16,
  parameter int AW  = 48,
  parameter int TPS = 1000
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire ltrap_pkg::ltrap_cmd_t                cmd_i,
  output ltrap_pkg::ltrap_stat_t                    stat_o,
  input  wire logic [ltrap_pkg::TAU_W-1:0]          tau_i,
  input  wire logic                                 in_cmd_i,
  input  wire logic signed [SW-1:0]                 in_smp_i,
  input  wire logic [ltrap_pkg::TIME_W-1:0]         in_ts_i,
  output logic signed [AW-1:0]                      out_int_o,
  output logic                                      out_sat_o
);
  localparam int DELTA_W   = ltrap_pkg::DELTA_W;
  localparam int MAG_W     = SW + 1;
  localparam int PROD_W    = MAG_W + DELTA_W;
  localparam int DIV_W     = PROD_W + 9;
  localparam int AREA_DVW  = $clog2(2 * TPS + 1);
  localparam int DVW       = ltrap_pkg::TAU_W;
  localparam int SUM_W     = ((AW > DIV_W + 1) ? AW : DIV_W + 1) + 1;
  localparam int ND        = (AW + 15) / 16;
  localparam int MW        = ND * 16;
  localparam int PW        = MW + ltrap_pkg::FACT_W;
  localparam int CNT_W     = $clog2(ND + 1);
  localparam int EXP_Y_W_FIX = ltrap_pkg::EXP_Y_W;
  localparam logic [DIV_W-1:0] AREA_BIAS    = DIV_W'(TPS);
  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'($signed({1'b0, {(AW-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] ACC_MIN = SUM_W'($signed({1'b1, {(AW-1){1'b0}}}));
  localparam logic [PW-1:0] MUL_ROUND = PW'(32'h8000);
  // area divide by 2*TPS: multiply by the rounded-up reciprocal, 16 bits a cycle
  localparam int RSHIFT    = DIV_W + AREA_DVW;
  localparam int RW        = DIV_W + 2;
  localparam int RND       = (DIV_W + 15) / 16;
  localparam int RXW       = RND * 16;
  localparam int RPW       = RXW + RW;
  localparam int RCNT_W    = $clog2(RND + 1);
  localparam logic [RSHIFT:0] POW_L   = {1'b1, {RSHIFT{1'b0}}};
  localparam logic [RSHIFT:0] DIV_L   = (RSHIFT+1)'(2 * TPS);
  localparam logic [RSHIFT:0] RECIP_L = (POW_L + DIV_L - 1'b1) / DIV_L;
  localparam logic [RW-1:0]   AREA_RECIP = RECIP_L[RW-1:0];

  // item registers
  logic                   cmd_q, cmd_d;
  logic signed [SW-1:0]   smp_q, smp_d;
  logic [31:0]            ts_q, ts_d;
  logic signed [SW:0]     s2_q, s2_d;
  logic [DELTA_W-1:0]     delta_q, delta_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  // state
  logic signed [AW-1:0]   sum_q, sum_d;
  logic                   sat_q, sat_d;
  logic signed [SW-1:0]   prev_smp_q, prev_smp_d;
  logic [31:0]            prev_time_q, prev_time_d;
  logic                   started_q, started_d;
  // exponential
  logic [ltrap_pkg::EXP_R_W-1:0] r_q, r_d;
  logic [ltrap_pkg::EXP_Y_W-1:0] y_q, y_d;
  logic [ltrap_pkg::EXP_K_W-1:0] k_q, k_d;
  // multiplier
  logic [MW-1:0]                 mag_q, mag_d;
  logic [ltrap_pkg::FACT_W-1:0]  f_q, f_d;
  logic [PW-1:0]                 macc_q, macc_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  // area divide
  logic                   rbusy_q, rbusy_d;
  logic [RCNT_W-1:0]      rcnt_q, rcnt_d;
  logic [RXW-1:0]         rx_q, rx_d;
  logic [RPW-1:0]         racc_q, racc_d;
  logic                   area_start;
  logic [DIV_W-1:0]       area_dividend;
  logic [DIV_W-1:0]       area_quo;
  // result
  logic signed [AW-1:0]   out_int_q, out_int_d;
  logic                   out_sat_q, out_sat_d;

  logic                   div_busy;
  logic [DIV_W-1:0]       div_quo;
  logic [DIV_W-1:0]       div_dividend;
  logic [DVW-1:0]         div_divisor;

  logic [31:0]            d32;
  logic [MAG_W-1:0]       s2_mag;
  logic signed [DIV_W:0]  area_s;
  logic signed [SUM_W-1:0] sum_new;
  logic [15:0]            step_c;
  logic [EXP_Y_W_FIX-1:0] y_rnd;
  logic [AW-1:0]          sum_mag;
  logic [PW-1:0]          p_full;
  logic [AW-1:0]          p_trunc;

  ltrap_div #(.DW(DIV_W), .DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start && cmd_i.div_decay),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Area divide: most significant digit first, quotient in the top bits
  always_comb begin
    area_start    = cmd_i.div_start && !cmd_i.div_decay;
    area_dividend = DIV_W'({prod_q, 8'h00}) + AREA_BIAS;
    area_quo      = DIV_W'(racc_q >> RSHIFT);
    rbusy_d       = rbusy_q;
    rcnt_d        = rcnt_q;
    rx_d          = rx_q;
    racc_d        = racc_q;
    if (area_start) begin
      rbusy_d = 1'b1;
      rcnt_d  = '0;
      rx_d    = RXW'(area_dividend);
      racc_d  = '0;
    end else if (rbusy_q) begin
      racc_d = (racc_q << 16) + RPW'(rx_q[RXW-1 -: 16] * AREA_RECIP);
      rx_d   = rx_q << 16;
      rcnt_d = rcnt_q + 1'b1;
      if (rcnt_q == RCNT_W'(RND - 1)) begin
        rbusy_d = 1'b0;
      end
    end
  end

  always_comb begin
    d32         = in_ts_i - prev_time_q;
    s2_mag      = s2_q[SW] ? MAG_W'(-s2_q) : MAG_W'(s2_q);
    area_s      = s2_q[SW] ? -$signed({1'b0, area_quo}) : $signed({1'b0, area_quo});
    sum_new     = SUM_W'(sum_q) + SUM_W'(area_s);
    step_c      = ltrap_pkg::decay_step(k_q);
    y_rnd       = y_q + ltrap_pkg::EXP_ROUND;
    sum_mag     = sum_q[AW-1] ? AW'(-sum_q) : AW'(sum_q);
    p_full      = macc_q + MUL_ROUND;
    p_trunc     = p_full[AW+15:16];

    div_dividend = DIV_W'({delta_q, 16'h0000});
    div_divisor  = DVW'(tau_i);

    cmd_d       = cmd_q;
    smp_d       = smp_q;
    ts_d        = ts_q;
    s2_d        = s2_q;
    delta_d     = delta_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    prev_smp_d  = prev_smp_q;
    prev_time_d = prev_time_q;
    started_d   = started_q;
    r_d         = r_q;
    y_d         = y_q;
    k_d         = k_q;
    mag_d       = mag_q;
    f_d         = f_q;
    macc_d      = macc_q;
    cnt_d       = cnt_q;
    out_int_d   = out_int_q;
    out_sat_d   = out_sat_q;

    if (cmd_i.capture) begin
      cmd_d   = in_cmd_i;
      smp_d   = in_smp_i;
      ts_d    = in_ts_i;
      s2_d    = (SW+1)'(in_smp_i) + (SW+1)'(prev_smp_q);
      delta_d = (d32[31:16] != 16'h0000) ? ltrap_pkg::DELTA_MAX : d32[15:0];
    end
    if (cmd_i.dec_clear) begin
      sum_d       = '0;
      sat_d       = 1'b0;
      prev_smp_d  = '0;
      prev_time_d = '0;
      started_d   = 1'b0;
    end
    if (cmd_i.dec_first) begin
      sat_d       = 1'b0;
      prev_smp_d  = smp_q;
      prev_time_d = ts_q;
      started_d   = 1'b1;
    end
    if (cmd_i.dec_hold) begin
      sat_d = 1'b0;
    end
    if (cmd_i.load_prod) begin
      prod_d = PROD_W'(s2_mag) * PROD_W'(delta_q);
    end
    if (cmd_i.add) begin
      // clip to the accumulator range
      if (sum_new > ACC_MAX) begin
        sum_d = AW'(ACC_MAX);
        sat_d = 1'b1;
      end else if (sum_new < ACC_MIN) begin
        sum_d = AW'(ACC_MIN);
        sat_d = 1'b1;
      end else begin
        sum_d = AW'(sum_new);
        sat_d = 1'b0;
      end
      prev_smp_d  = smp_q;
      prev_time_d = ts_q;
    end
    if (cmd_i.exp_init) begin
      // a quotient of 16.0 or more gives a zero factor
      if (div_quo[DIV_W-1:ltrap_pkg::EXP_R_W] != '0) begin
        y_d = '0;
        k_d = ltrap_pkg::EXP_K_END;
      end else begin
        r_d = div_quo[ltrap_pkg::EXP_R_W-1:0];
        y_d = ltrap_pkg::EXP_Y_ONE;
        k_d = ltrap_pkg::EXP_K_FIRST;
      end
    end
    if (cmd_i.exp_step) begin
      if (r_q >= ltrap_pkg::EXP_R_W'(step_c)) begin
        r_d = r_q - ltrap_pkg::EXP_R_W'(step_c);
        y_d = y_q - (y_q >> k_q);
      end else begin
        k_d = k_q + 1'b1;
      end
    end
    if (cmd_i.mul_init) begin
      mag_d  = MW'(sum_mag);
      f_d    = y_rnd[EXP_Y_W_FIX-1:14];
      macc_d = '0;
      cnt_d  = '0;
    end
    if (cmd_i.mul_step) begin
      // most significant digit first
      macc_d = (macc_q << 16) + PW'(mag_q[MW-1 -: 16] * f_q);
      mag_d  = mag_q << 16;
      cnt_d  = cnt_q + 1'b1;
    end
    if (cmd_i.mul_round) begin
      sum_d = sum_q[AW-1] ? -$signed(p_trunc) : $signed(p_trunc);
    end
    if (cmd_i.out_load) begin
      out_int_d = sum_q;
      out_sat_d = sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sat_q       <= 1'b0;
      prev_smp_q  <= '0;
      prev_time_q <= '0;
      started_q   <= 1'b0;
      k_q         <= ltrap_pkg::EXP_K_END;
      cnt_q       <= '0;
      rbusy_q     <= 1'b0;
      rcnt_q      <= '0;
    end else begin
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      prev_smp_q  <= prev_smp_d;
      prev_time_q <= prev_time_d;
      started_q   <= started_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      rbusy_q     <= rbusy_d;
      rcnt_q      <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    smp_q     <= smp_d;
    ts_q      <= ts_d;
    s2_q      <= s2_d;
    delta_q   <= delta_d;
    prod_q    <= prod_d;
    r_q       <= r_d;
    y_q       <= y_d;
    mag_q     <= mag_d;
    f_q       <= f_d;
    macc_q    <= macc_d;
    rx_q      <= rx_d;
    racc_q    <= racc_d;
    out_int_q <= out_int_d;
    out_sat_q <= out_sat_d;
  end

  always_comb begin
    stat_o.clear    = (cmd_q == ltrap_pkg::CMD_CLEAR);
    stat_o.started  = started_q;
    stat_o.same_ts  = (ts_q == prev_time_q);
    stat_o.tau_zero = (tau_i == '0);
    stat_o.div_busy = div_busy || rbusy_q;
    stat_o.exp_done = (k_q == ltrap_pkg::EXP_K_END);
    stat_o.mul_done = (cnt_q == CNT_W'(ND));
  end

  assign out_int_o = out_int_q;
  assign out_sat_o = out_sat_q;
endmodule
`default_nettype wire

// ===== design/ltrap_ctrl.sv =====
`default_nettype none
module ltrap_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire ltrap_pkg::ltrap_stat_t stat_i,
  output ltrap_pkg::ltrap_cmd_t       cmd_o
);
  ltrap_pkg::ltrap_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ltrap_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ltrap_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ltrap_pkg::S_DECODE;
        end
      end
      ltrap_pkg::S_DECODE: begin
        if (stat_i.clear) begin
          cmd_o.dec_clear = 1'b1;
          state_d         = ltrap_pkg::S_FINISH;
        end else if (!stat_i.started) begin
          cmd_o.dec_first = 1'b1;
          state_d         = ltrap_pkg::S_FINISH;
        end else if (stat_i.same_ts) begin
          cmd_o.dec_hold = 1'b1;
          state_d        = ltrap_pkg::S_FINISH;
        end else begin
          cmd_o.load_prod = 1'b1;
          state_d         = ltrap_pkg::S_DIV_AREA;
        end
      end
      ltrap_pkg::S_DIV_AREA: begin
        cmd_o.div_start = 1'b1;
        state_d         = ltrap_pkg::S_WAIT_AREA;
      end
      ltrap_pkg::S_WAIT_AREA: begin
        if (!stat_i.div_busy) begin
          state_d = ltrap_pkg::S_ADD;
        end
      end
      ltrap_pkg::S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = stat_i.tau_zero ? ltrap_pkg::S_FINISH : ltrap_pkg::S_DIV_DECAY;
      end
      ltrap_pkg::S_DIV_DECAY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_decay = 1'b1;
        state_d         = ltrap_pkg::S_WAIT_DECAY;
      end
      ltrap_pkg::S_WAIT_DECAY: begin
        if (!stat_i.div_busy) begin
          state_d = ltrap_pkg::S_EXP_INIT;
        end
      end
      ltrap_pkg::S_EXP_INIT: begin
        cmd_o.exp_init = 1'b1;
        state_d        = ltrap_pkg::S_EXP;
      end
      ltrap_pkg::S_EXP: begin
        if (stat_i.exp_done) begin
          state_d = ltrap_pkg::S_MUL_INIT;
        end else begin
          cmd_o.exp_step = 1'b1;
        end
      end
      ltrap_pkg::S_MUL_INIT: begin
        cmd_o.mul_init = 1'b1;
        state_d        = ltrap_pkg::S_MUL;
      end
      ltrap_pkg::S_MUL: begin
        if (stat_i.mul_done) begin
          state_d = ltrap_pkg::S_ROUND;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      ltrap_pkg::S_ROUND: begin
        cmd_o.mul_round = 1'b1;
        state_d         = ltrap_pkg::S_FINISH;
      end
      ltrap_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ltrap_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ltrap_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ltrap_pkg::S_DECODE))
    else $error("accepted transaction did not reach decode");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !stat_i.div_busy)
    else $error("divider started while busy");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ltrap_pkg::S_FINISH))
    else $error("result raised outside finish");
`endif
endmodule
`default_nettype wire

// ===== design/leaky_trapezoid_integrator.sv =====
// Flow: a clear, a first sample or a repeated timestamp goes from decode straight to
//   the result; otherwise the area divide and saturating add follow, and with a nonzero
//   time constant the decay divide, exponential and decay multiply come after them.
// Throughput: one transaction in flight, the next accepted in the cycle after the result
//   is loaded; the decay divider and the exponential set the pace.
// Reset: rst_ni clears the sum, stored sample and time, the start flag and the register.
`default_nettype none
module leaky_trapezoid_integrator #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int ACC_WIDTH        = 48,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  ltrap_in_if.sink                                in_i,
  ltrap_out_if.source                             out_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ltrap_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [ltrap_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ltrap_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                    pready
);
  ltrap_pkg::ltrap_cmd_t  cmd;
  ltrap_pkg::ltrap_stat_t stat;

  logic [ltrap_pkg::TAU_W-1:0] tau_q, tau_d;
  logic [0:0]                  reg_index;
  logic                        cfg_write;

  // Configuration: one register, the decay time constant, at word 0.
  assign reg_index = paddr[ltrap_pkg::APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    tau_d = tau_q;
    if (cfg_write && (reg_index == ltrap_pkg::REG_TIME_CONSTANT)) begin
      tau_d = pwdata[ltrap_pkg::TAU_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q <= '0;
    end else begin
      tau_q <= tau_d;
    end
  end

  // Read back the register; other addresses read as zero.
  always_comb begin
    if (reg_index == ltrap_pkg::REG_TIME_CONSTANT) begin
      prdata = ltrap_pkg::APB_DATA_W'(tau_q);
    end else begin
      prdata = '0;
    end
  end

  // Sequencer: walks decode, area divide, saturating add, decay divide,
  // exponential and digit-serial decay multiply, then hands the result over.
  ltrap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and integrator state; the result register parts the output side.
  ltrap_dp #(
    .SW  (SAMPLE_WIDTH),
    .AW  (ACC_WIDTH),
    .TPS (TICKS_PER_SECOND)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .tau_i     (tau_q),
    .in_cmd_i  (in_i.command),
    .in_smp_i  (in_i.sample_value),
    .in_ts_i   (in_i.timestamp_ms),
    .out_int_o (out_o.integral_value),
    .out_sat_o (out_o.saturated)
  );
endmodule
`default_nettype wire

// ===== test/leaky_trapezoid_integrator_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module leaky_trapezoid_integrator_tb;

  localparam int SW = 16;
  localparam int AW = 48;
  localparam int TPS = 1000;
  localparam int MAX_WAIT = 14;

  typedef struct packed {
    logic             command;
    logic signed [15:0] sample_value;
    logic [31:0]      timestamp_ms;
  } sample_item_t;

  typedef struct packed {
    logic signed [47:0] integral_value;
    logic               saturated;
  } integral_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ltrap_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [ltrap_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [ltrap_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  ltrap_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  ltrap_out_if #(.ACC_WIDTH(AW))    out_ch ();

  leaky_trapezoid_integrator #(
    .SAMPLE_WIDTH(SW), .ACC_WIDTH(AW), .TICKS_PER_SECOND(TPS)
  ) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted state of the integrator
  logic signed [63:0] sum_q;
  logic signed [15:0] prev_smp_q;
  logic [31:0]        prev_ts_q;
  logic               started_q;
  logic [15:0]        tau_q;

  sample_item_t pending_samples[$];
  integral_t    expected_integrals[$];
  int           error_count = 0;
  int           accepted_count = 0;
  bit           hold_sender = 1'b0;

  localparam logic [15:0] DECAY_STEP_TBL [1:16] = '{
    16'd45426, 16'd18854, 16'd8751, 16'd4230, 16'd2081, 16'd1032, 16'd514, 16'd257,
    16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2, 16'd1
  };

  function automatic logic [16:0] exp_factor(logic [15:0] delta, logic [15:0] tau);
    logic [47:0] q;
    logic [31:0] y, r;
    q = ({32'd0, delta} << 16) / tau;
    if (q >= (48'd16 << 16)) return 17'd0;
    y = 32'h4000_0000;
    r = q[31:0];
    for (int k = 1; k <= 16; k++) begin
      while (r >= DECAY_STEP_TBL[k]) begin
        r = r - DECAY_STEP_TBL[k];
        y = y - (y >> k);
      end
    end
    return 17'((y + 32'h2000) >> 14);
  endfunction

  // Advance the predicted state by one transaction and return its result
  function automatic integral_t integrate_sample(sample_item_t it);
    integral_t res;
    logic [31:0] dt;
    logic signed [63:0] s2, area, amax, amin;
    logic [63:0] mag, a, p;
    logic [16:0] f;
    res.saturated = 1'b0;
    amax = (64'sd1 <<< (AW - 1)) - 1;
    amin = -amax - 1;
    if (it.command == ltrap_pkg::CMD_CLEAR) begin
      sum_q = 0; prev_smp_q = 0; prev_ts_q = 0; started_q = 1'b0;
      res.integral_value = '0;
    end else if (!started_q) begin
      prev_smp_q = it.sample_value; prev_ts_q = it.timestamp_ms; started_q = 1'b1;
      res.integral_value = '0;
    end else if (it.timestamp_ms == prev_ts_q) begin
      res.integral_value = sum_q[47:0];
    end else begin
      dt = it.timestamp_ms - prev_ts_q;
      if (dt > 32'hFFFF) dt = 32'hFFFF;
      s2 = 64'(it.sample_value) + 64'(prev_smp_q);
      mag = (s2 < 0) ? 64'(-s2) : 64'(s2);
      a = (mag * dt * 256 + TPS) / (2 * TPS);
      area = (s2 < 0) ? -$signed(a) : $signed(a);
      if (area > 0 && sum_q > amax - area) begin
        sum_q = amax; res.saturated = 1'b1;
      end else if (area < 0 && sum_q < amin - area) begin
        sum_q = amin; res.saturated = 1'b1;
      end else begin
        sum_q = sum_q + area;
      end
      if (tau_q != 0) begin
        f = exp_factor(dt[15:0], tau_q);
        if (f < 17'h10000) begin
          mag = (sum_q < 0) ? 64'(-sum_q) : 64'(sum_q);
          p = (mag >> 16) * f + (((mag & 64'hFFFF) * f + 64'h8000) >> 16);
          sum_q = (sum_q < 0) ? -$signed(p) : $signed(p);
        end
      end
      prev_smp_q = it.sample_value; prev_ts_q = it.timestamp_ms;
      res.integral_value = sum_q[47:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: present one queued sample per transaction, with a random gap before each
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.command <= ltrap_pkg::CMD_PROCESS;
      in_ch.sample_value <= '0;
      in_ch.timestamp_ms <= '0;
      send_gap <= $urandom_range(0, MAX_WAIT);
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_integrals.push_back(integrate_sample({in_ch.command, in_ch.sample_value,
                                                       in_ch.timestamp_ms}));
        accepted_count++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the current transaction
      end else if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() > 0 && !hold_sender) begin
        sample_item_t it;
        it = pending_samples.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.command <= it.command;
        in_ch.sample_value <= it.sample_value;
        in_ch.timestamp_ms <= it.timestamp_ms;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls on ready, compare each result with the oldest prediction
  int stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_integrals.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_ch.integral_value), 64'd0);
        end else begin
          integral_t want;
          want = expected_integrals.pop_front();
          if (out_ch.integral_value !== want.integral_value)
            report_mismatch("integral_value", 64'(out_ch.integral_value),
                            64'(want.integral_value));
          if (out_ch.saturated !== want.saturated)
            report_mismatch("saturated", 64'(out_ch.saturated), 64'(want.saturated));
        end
        stall <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_tau(logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= '0; pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tau_q = value;
  endtask

  // Let every queued sample go through and drain the results before a register write
  task automatic drain();
    while (pending_samples.size() > 0 || in_ch.valid || expected_integrals.size() > 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic queue_sample(logic cmd, logic [15:0] smp, logic [31:0] ts);
    pending_samples.push_back('{command: cmd, sample_value: smp, timestamp_ms: ts});
  endtask

  // One random run of samples: mostly forward steps, some repeats, clears and wraps
  task automatic queue_random(int count);
    logic [31:0] ts;
    int pick;
    ts = $urandom;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        queue_sample(ltrap_pkg::CMD_CLEAR, 16'($urandom), $urandom);
      end else begin
        if (pick < 10) ts = ts;
        else if (pick < 20) ts = ts + $urandom;
        else if (pick < 30) ts = ts + $urandom_range(0, 70000);
        else ts = ts + $urandom_range(1, 50);
        if ($urandom_range(0, 9) == 0)
          queue_sample(ltrap_pkg::CMD_PROCESS,
                       $urandom_range(0, 1) ? 16'h7FFF : 16'h8000, ts);
        else
          queue_sample(ltrap_pkg::CMD_PROCESS, 16'($urandom), ts);
      end
    end
  endtask

  logic [15:0] tau_list[6] = '{16'd0, 16'd1, 16'd65535, 16'd100, 16'd1000, 16'd7};

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    sum_q = 0; prev_smp_q = 0; prev_ts_q = 0; started_q = 1'b0; tau_q = 0;

    // Directed: first sample, repeat, extremes, long gap and wrap
    queue_sample(ltrap_pkg::CMD_PROCESS, 16'h7FFF, 32'hFFFF_FFF0);
    queue_sample(ltrap_pkg::CMD_PROCESS, 16'h7FFF, 32'hFFFF_FFF0);
    queue_sample(ltrap_pkg::CMD_PROCESS, 16'h7FFF, 32'h0000_0010);
    for (int i = 0; i < 12; i++)
      queue_sample(ltrap_pkg::CMD_PROCESS, 16'h7FFF,
                   32'h0000_0010 + 32'h0010_0000 * (i + 1));
    queue_sample(ltrap_pkg::CMD_PROCESS, 16'h8000, 32'hF000_0000);
    for (int i = 0; i < 6; i++)
      queue_sample(ltrap_pkg::CMD_PROCESS, 16'h8000,
                   32'hF000_0000 + 32'h0002_0000 * (i + 1));
    queue_sample(ltrap_pkg::CMD_PROCESS, 16'h0001, 32'hFFFF_FFFF);
    queue_sample(ltrap_pkg::CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    queue_sample(ltrap_pkg::CMD_PROCESS, 16'h0000, 32'h0000_0000);
    drain();

    // Random phases across register settings, extremes included
    foreach (tau_list[j]) begin
      write_tau(tau_list[j]);
      queue_random(150);
      // pause the sender until the block has caught up
      if (j == 2) begin
        hold_sender = 1'b1;
        queue_random(10);
        while (in_ch.valid || expected_integrals.size() > 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      drain();
    end
    for (int j = 0; j < 5; j++) begin
      write_tau(16'($urandom_range(1, 65535)));
      queue_random(200);
      drain();
    end

    if (error_count == 0) begin
      $display("leaky_trapezoid_integrator_tb: clean");
    end else begin
      $display("leaky_trapezoid_integrator_tb: errors");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #40ms;
    $display("leaky_trapezoid_integrator_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
